[rtl/dq_pkg.sv]
package dq_pkg;

  // Operation codes carried on the mode field
  localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [2:0] MODE_POP_BACK   = 3'd3;
  localparam logic [2:0] MODE_QUERY      = 3'd4;

  localparam int WORD_W  = 32;
  localparam int COUNT_W = 11;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_OUT
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic exec;  // carry out the operation of the item at the input
    logic load;  // take the fetched word into the end cache
  } dq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_fetch;  // the pending operation leaves an end word in memory
  } dq_status_t;

endpackage

[rtl/dq_ctrl.sv]
module dq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  dq_pkg::dq_status_t status,
  output dq_pkg::dq_cmd_t    cmd
);
  import dq_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance through accept, optional fetch, and result delivery
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = status.need_fetch ? ST_LOAD : ST_OUT;
        end
      end
      ST_LOAD: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Drive handshake and datapath commands
  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    cmd.exec  = 1'b0;
    cmd.load  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.exec = in_valid;
      end
      ST_LOAD: begin
        cmd.load = 1'b1;
      end
      ST_OUT: begin
        out_valid = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

[rtl/dq_datapath.sv]
module dq_datapath #(
  parameter int DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  dq_pkg::dq_cmd_t                     cmd,
  output dq_pkg::dq_status_t                  status,
  input  logic [2:0]                          mode,
  input  logic signed [dq_pkg::WORD_W-1:0]    push_value,
  output logic signed [dq_pkg::WORD_W-1:0]    popped_value,
  output logic                                pop_ok,
  output logic                                push_overflow,
  output logic [dq_pkg::COUNT_W-1:0]          entry_count,
  output logic                                is_empty,
  output logic signed [dq_pkg::WORD_W-1:0]    front_value,
  output logic signed [dq_pkg::WORD_W-1:0]    back_value
);
  import dq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_POS  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_CNT   = CW'(1);
  localparam logic [CW-1:0] TWO_CNT   = CW'(2);

  // Word storage, never cleared: only occupied entries are read
  logic [WORD_W-1:0] mem [DEPTH];

  // Pointers: head is the front word, tail is the back word
  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic [CW-1:0] count;
  logic [AW-1:0] head_next;
  logic [AW-1:0] tail_next;
  logic [CW-1:0] count_next;

  // Cached end words, so results need no extra memory read
  logic signed [WORD_W-1:0] front_word;
  logic signed [WORD_W-1:0] back_word;
  logic signed [WORD_W-1:0] front_word_next;
  logic signed [WORD_W-1:0] back_word_next;

  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [WORD_W-1:0]   rd_data;
  logic                fetch_front_next;
  logic                fetch_front;

  logic signed [WORD_W-1:0] popped_next;
  logic                     ok_next;
  logic                     ovf_next;

  logic full;
  logic empty;
  logic [AW-1:0] head_inc;
  logic [AW-1:0] head_dec;
  logic [AW-1:0] tail_inc;
  logic [AW-1:0] tail_dec;
  logic [CW+COUNT_W-1:0] count_ext;

  assign full  = (count == FULL_CNT);
  assign empty = (count == '0);

  // Wrap pointer steps around the ring
  assign head_inc = (head == LAST_POS) ? '0 : head + AW'(1);
  assign head_dec = (head == '0) ? LAST_POS : head - AW'(1);
  assign tail_inc = (tail == LAST_POS) ? '0 : tail + AW'(1);
  assign tail_dec = (tail == '0) ? LAST_POS : tail - AW'(1);

  // Decode the operation
  always_comb begin
    head_next        = head;
    tail_next        = tail;
    count_next       = count;
    front_word_next  = front_word;
    back_word_next   = back_word;
    wr_en            = 1'b0;
    wr_addr          = head;
    rd_en            = 1'b0;
    rd_addr          = head;
    fetch_front_next = 1'b1;
    popped_next      = '0;
    ok_next          = 1'b0;
    ovf_next         = 1'b0;
    case (mode)
      MODE_PUSH_FRONT: begin
        if (full) begin
          ovf_next = 1'b1;
        end else begin
          head_next       = head_dec;
          count_next      = count + CW'(1);
          wr_en           = 1'b1;
          wr_addr         = head_dec;
          front_word_next = push_value;
          if (empty) begin
            back_word_next = push_value;
          end
        end
      end
      MODE_PUSH_BACK: begin
        if (full) begin
          ovf_next = 1'b1;
        end else begin
          tail_next      = tail_inc;
          count_next     = count + CW'(1);
          wr_en          = 1'b1;
          wr_addr        = tail_inc;
          back_word_next = push_value;
          if (empty) begin
            front_word_next = push_value;
          end
        end
      end
      MODE_POP_FRONT: begin
        if (!empty) begin
          popped_next = front_word;
          ok_next     = 1'b1;
          head_next   = head_inc;
          count_next  = count - CW'(1);
          if (count == TWO_CNT) begin
            front_word_next = back_word;
          end else if (count != ONE_CNT) begin
            rd_en            = 1'b1;
            rd_addr          = head_inc;
            fetch_front_next = 1'b1;
          end
        end
      end
      MODE_POP_BACK: begin
        if (!empty) begin
          popped_next = back_word;
          ok_next     = 1'b1;
          tail_next   = tail_dec;
          count_next  = count - CW'(1);
          if (count == TWO_CNT) begin
            back_word_next = front_word;
          end else if (count != ONE_CNT) begin
            rd_en            = 1'b1;
            rd_addr          = tail_dec;
            fetch_front_next = 1'b0;
          end
        end
      end
      default: begin
        ovf_next = 1'b0;
      end
    endcase
  end

  assign status.need_fetch = rd_en;

  // Write and read the word store
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[wr_addr] <= push_value;
    end
    if (cmd.exec && rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Hold pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= LAST_POS;
      count <= '0;
    end else if (cmd.exec) begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  // Update end caches and result fields
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      front_word    <= front_word_next;
      back_word     <= back_word_next;
      fetch_front   <= fetch_front_next;
      popped_value  <= popped_next;
      pop_ok        <= ok_next;
      push_overflow <= ovf_next;
    end else if (cmd.load) begin
      if (fetch_front) begin
        front_word <= rd_data;
      end else begin
        back_word <= rd_data;
      end
    end
  end

  // Report occupancy and end words
  assign count_ext   = {{COUNT_W{1'b0}}, count};
  assign entry_count = count_ext[COUNT_W-1:0];
  assign is_empty    = empty;
  assign front_value = empty ? '0 : front_word;
  assign back_value  = empty ? '0 : back_word;

endmodule

[rtl/double_ended_queue.sv]
// Double-ended queue of signed 32-bit words in a ring of DEPTH entries.
// Result valid in ST_OUT, reached from ST_IDLE on accept, or via ST_LOAD when
// a pop must fetch the new front or back word from the single-read-port word
// store. No new item is taken until the last result is taken; the next item
// is taken in the cycle after that. Reset clears the pointers and the count;
// the word store is not cleared, so it accepts items right after reset.
module double_ended_queue #(
  parameter int DEPTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        mode,
  input  logic signed [dq_pkg::WORD_W-1:0]  push_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [dq_pkg::WORD_W-1:0]  popped_value,
  output logic                              pop_ok,
  output logic                              push_overflow,
  output logic [dq_pkg::COUNT_W-1:0]        entry_count,
  output logic                              is_empty,
  output logic signed [dq_pkg::WORD_W-1:0]  front_value,
  output logic signed [dq_pkg::WORD_W-1:0]  back_value
);
  import dq_pkg::*;

  dq_cmd_t    cmd;
  dq_status_t status;

  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  dq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .mode          (mode),
    .push_value    (push_value),
    .popped_value  (popped_value),
    .pop_ok        (pop_ok),
    .push_overflow (push_overflow),
    .entry_count   (entry_count),
    .is_empty      (is_empty),
    .front_value   (front_value),
    .back_value    (back_value)
  );

endmodule

[test/tb.sv]
`timescale 1ns / 100ps

module tb;
  import dq_pkg::*;

  localparam int Q_DEPTH     = 1024;
  localparam int LIMIT_CYCLES = 250000;
  localparam int DRAIN_CYCLES = 8;

  // Undefined operation codes, which the block treats as a query
  localparam logic [2:0] MODE_RSVD_LO  = 3'd5;
  localparam logic [2:0] MODE_RSVD_MID = 3'd6;
  localparam logic [2:0] MODE_RSVD_HI  = 3'd7;

  typedef struct packed {
    logic signed [WORD_W-1:0]  popped;
    logic                      ok;
    logic                      ovf;
    logic        [COUNT_W-1:0] count;
    logic                      empty;
    logic signed [WORD_W-1:0]  front;
    logic signed [WORD_W-1:0]  back;
  } deque_report_t;

  typedef struct packed {
    logic [2:0]          op;
    logic [WORD_W-1:0]   value;
    logic                typed;
    deque_report_t       report;
  } dir_row_t;

  localparam int DIR_ROWS = 24;

  // Directed rows: empty-queue cases, undefined modes, word extremes at both ends
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{MODE_QUERY,      32'h0,        1'b1, '{32'h0, 1'b0, 1'b0, 11'd0, 1'b1, 32'h0, 32'h0}},
    '{MODE_POP_FRONT,  32'h0,        1'b1, '{32'h0, 1'b0, 1'b0, 11'd0, 1'b1, 32'h0, 32'h0}},
    '{MODE_POP_BACK,   32'h0,        1'b1, '{32'h0, 1'b0, 1'b0, 11'd0, 1'b1, 32'h0, 32'h0}},
    '{MODE_RSVD_LO,    32'h1,        1'b1, '{32'h0, 1'b0, 1'b0, 11'd0, 1'b1, 32'h0, 32'h0}},
    '{MODE_PUSH_BACK,  32'h7fffffff, 1'b1,
      '{32'h0, 1'b0, 1'b0, 11'd1, 1'b0, 32'h7fffffff, 32'h7fffffff}},
    '{MODE_PUSH_FRONT, 32'h80000000, 1'b1,
      '{32'h0, 1'b0, 1'b0, 11'd2, 1'b0, 32'h80000000, 32'h7fffffff}},
    '{MODE_PUSH_BACK,  32'h0,        1'b1,
      '{32'h0, 1'b0, 1'b0, 11'd3, 1'b0, 32'h80000000, 32'h0}},
    '{MODE_PUSH_FRONT, 32'hffffffff, 1'b1,
      '{32'h0, 1'b0, 1'b0, 11'd4, 1'b0, 32'hffffffff, 32'h0}},
    '{MODE_RSVD_MID,   32'hdeadbeef, 1'b1,
      '{32'h0, 1'b0, 1'b0, 11'd4, 1'b0, 32'hffffffff, 32'h0}},
    '{MODE_RSVD_HI,    32'hffffffff, 1'b1,
      '{32'h0, 1'b0, 1'b0, 11'd4, 1'b0, 32'hffffffff, 32'h0}},
    '{MODE_POP_BACK,   32'h0,        1'b1,
      '{32'h0, 1'b1, 1'b0, 11'd3, 1'b0, 32'hffffffff, 32'h7fffffff}},
    '{MODE_POP_FRONT,  32'h0,        1'b1,
      '{32'hffffffff, 1'b1, 1'b0, 11'd2, 1'b0, 32'h80000000, 32'h7fffffff}},
    '{MODE_POP_FRONT,  32'h0,        1'b1,
      '{32'h80000000, 1'b1, 1'b0, 11'd1, 1'b0, 32'h7fffffff, 32'h7fffffff}},
    '{MODE_POP_BACK,   32'h0,        1'b1,
      '{32'h7fffffff, 1'b1, 1'b0, 11'd0, 1'b1, 32'h0, 32'h0}},
    '{MODE_POP_BACK,   32'hffffffff, 1'b1, '{32'h0, 1'b0, 1'b0, 11'd0, 1'b1, 32'h0, 32'h0}},
    '{MODE_PUSH_FRONT, 32'h55555555, 1'b1,
      '{32'h0, 1'b0, 1'b0, 11'd1, 1'b0, 32'h55555555, 32'h55555555}},
    '{MODE_POP_FRONT,  32'h0,        1'b1,
      '{32'h55555555, 1'b1, 1'b0, 11'd0, 1'b1, 32'h0, 32'h0}},
    '{MODE_PUSH_BACK,  32'haaaaaaaa, 1'b0, '0},
    '{MODE_PUSH_FRONT, 32'h12345678, 1'b0, '0},
    '{MODE_PUSH_BACK,  32'hedcba987, 1'b0, '0},
    '{MODE_QUERY,      32'h0,        1'b0, '0},
    '{MODE_POP_BACK,   32'h0,        1'b0, '0},
    '{MODE_POP_BACK,   32'h0,        1'b0, '0},
    '{MODE_POP_FRONT,  32'h0,        1'b0, '0}
  };

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [2:0]                 mode = MODE_QUERY;
  logic signed [WORD_W-1:0]   push_value = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [WORD_W-1:0]   popped_value;
  logic                       pop_ok;
  logic                       push_overflow;
  logic [COUNT_W-1:0]         entry_count;
  logic                       is_empty;
  logic signed [WORD_W-1:0]   front_value;
  logic signed [WORD_W-1:0]   back_value;

  // Shadow copy of the ring
  logic [WORD_W-1:0] dq_words [Q_DEPTH];
  int unsigned       dq_head = 0;
  int unsigned       dq_fill = 0;

  deque_report_t report_q [$];
  deque_report_t got_report;
  deque_report_t want_report;

  int fail_count   = 0;
  int ops_sent     = 0;
  int reports_seen = 0;
  int drops_seen   = 0;
  int empty_pops   = 0;
  int peak_fill    = 0;
  int burst_left   = 0;
  int stall_pct    = 0;
  int stall_left   = 0;
  int cycle_count  = 0;

  double_ended_queue #(.DEPTH(Q_DEPTH)) u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .push_value   (push_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .popped_value (popped_value),
    .pop_ok       (pop_ok),
    .push_overflow(push_overflow),
    .entry_count  (entry_count),
    .is_empty     (is_empty),
    .front_value  (front_value),
    .back_value   (back_value)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Apply one operation to the shadow ring and return the report it gives
  function automatic deque_report_t deque_apply(input logic [2:0] op,
                                                input logic [WORD_W-1:0] val);
    deque_report_t r;
    r = '0;
    case (op)
      MODE_PUSH_FRONT: begin
        if (dq_fill == Q_DEPTH) begin
          r.ovf = 1'b1;
        end else begin
          dq_head = (dq_head + Q_DEPTH - 1) % Q_DEPTH;
          dq_words[dq_head] = val;
          dq_fill++;
        end
      end
      MODE_PUSH_BACK: begin
        if (dq_fill == Q_DEPTH) begin
          r.ovf = 1'b1;
        end else begin
          dq_words[(dq_head + dq_fill) % Q_DEPTH] = val;
          dq_fill++;
        end
      end
      MODE_POP_FRONT: begin
        if (dq_fill != 0) begin
          r.popped = dq_words[dq_head];
          r.ok = 1'b1;
          dq_head = (dq_head + 1) % Q_DEPTH;
          dq_fill--;
        end
      end
      MODE_POP_BACK: begin
        if (dq_fill != 0) begin
          r.popped = dq_words[(dq_head + dq_fill - 1) % Q_DEPTH];
          r.ok = 1'b1;
          dq_fill--;
        end
      end
      default: ;
    endcase
    r.count = COUNT_W'(dq_fill);
    r.empty = (dq_fill == 0);
    if (dq_fill != 0) begin
      r.front = dq_words[dq_head];
      r.back  = dq_words[(dq_head + dq_fill - 1) % Q_DEPTH];
    end
    return r;
  endfunction

  // Mostly random words, with the sign and magnitude extremes mixed in
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(15))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return 32'h0;
      3: return 32'hffffffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_query_mode();
    case ($urandom_range(3))
      0: return MODE_QUERY;
      1: return MODE_RSVD_LO;
      2: return MODE_RSVD_MID;
      default: return MODE_RSVD_HI;
    endcase
  endfunction

  // Present one item, hold it until taken, then log its expected report
  task automatic send_op(input logic [2:0] op, input logic [WORD_W-1:0] val,
                         input logic typed, input deque_report_t typed_report);
    deque_report_t r;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid   <= 1'b1;
    mode       <= op;
    push_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if ((op == MODE_POP_FRONT || op == MODE_POP_BACK) && dq_fill == 0) empty_pops++;
    r = deque_apply(op, val);
    report_q.insert(report_q.size(), typed ? typed_report : r);
    ops_sent++;
    if (dq_fill > peak_fill) peak_fill = dq_fill;
  endtask

  // Receiver: stall with a duty cycle that changes every so often
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        case ($urandom_range(3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
        stall_left = $urandom_range(16, 96);
      end
      stall_left--;
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Check each taken report against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got_report = {popped_value, pop_ok, push_overflow, entry_count, is_empty,
                    front_value, back_value};
      reports_seen++;
      if (report_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected report at cycle %0d: %p", cycle_count, got_report);
      end else begin
        want_report = report_q[0];
        report_q.delete(0);
        if (want_report.ovf) drops_seen++;
        if (got_report !== want_report) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch at cycle %0d", cycle_count);
            $display("  exp popped=%h ok=%b ovf=%b count=%0d empty=%b front=%h back=%h",
                     want_report.popped, want_report.ok, want_report.ovf,
                     want_report.count, want_report.empty, want_report.front,
                     want_report.back);
            $display("  got popped=%h ok=%b ovf=%b count=%0d empty=%b front=%h back=%h",
                     got_report.popped, got_report.ok, got_report.ovf,
                     got_report.count, got_report.empty, got_report.front,
                     got_report.back);
          end
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d reports outstanding", cycle_count,
               report_q.size());
      $display("** double_ended_queue: FAILED **");
      $finish;
    end
  end

  initial begin
    int pick;
    logic [2:0] op;

    // Hold reset, then release
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    for (int i = 0; i < DIR_ROWS; i++)
      send_op(dir_rows[i].op, dir_rows[i].value, dir_rows[i].typed, dir_rows[i].report);

    // Random mix around empty, undefined modes included
    for (int i = 0; i < 40; i++)
      send_op(3'($urandom_range(7)), pick_word(), 1'b0, '0);

    // Fill to the top with push-heavy traffic
    while (dq_fill < Q_DEPTH) begin
      pick = $urandom_range(99);
      if (pick < 49)      op = MODE_PUSH_FRONT;
      else if (pick < 98) op = MODE_PUSH_BACK;
      else if (pick < 99) op = $urandom_range(1) ? MODE_POP_FRONT : MODE_POP_BACK;
      else                op = pick_query_mode();
      send_op(op, pick_word(), 1'b0, '0);
    end

    // Work at and around full: dropped pushes, pops from both ends
    for (int i = 0; i < 60; i++) begin
      pick = $urandom_range(99);
      if (pick < 35)      op = $urandom_range(1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
      else if (pick < 85) op = $urandom_range(1) ? MODE_POP_FRONT : MODE_POP_BACK;
      else                op = pick_query_mode();
      send_op(op, pick_word(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    // Drain outstanding reports, then let the block settle
    while (report_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d items, checked %0d reports in %0d cycles", ops_sent,
             reports_seen, cycle_count);
    $display("peak fill %0d of %0d, %0d dropped pushes, %0d pops on an empty queue",
             peak_fill, Q_DEPTH, drops_seen, empty_pops);
    if (fail_count == 0 && report_q.size() == 0) begin
      $display("** double_ended_queue: PASSED **");
    end else begin
      $display("** double_ended_queue: FAILED **");
    end
    $finish;
  end

endmodule

[double_ended_queue.f]
rtl/dq_pkg.sv
rtl/dq_ctrl.sv
rtl/dq_datapath.sv
rtl/double_ended_queue.sv
test/tb.sv
